### rtl/rmq_pkg.sv
package rmq_pkg;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned CFG_LEN_W = 11;

  localparam logic [CFG_LEN_W-1:0] LEN_RESET = 11'd1024;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [VAL_W-1:0] value_t;

  localparam value_t INT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] element_index;
    value_t           element_value;
    logic [IDX_W-1:0] range_start;
    logic [IDX_W-1:0] range_end;
  } in_word_t;

  typedef struct packed {
    value_t max_value;
    logic   empty_res;
  } out_word_t;

  function automatic value_t smax(input value_t a, input value_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

### rtl/rmq_node_ram.sv
module rmq_node_ram #(
  parameter int unsigned DEPTH = 2048
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  rmq_pkg::value_t            wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output rmq_pkg::value_t            rdata_o
);
  import rmq_pkg::*;

  value_t mem [DEPTH];
  value_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rmq_ctrl.sv
module rmq_ctrl #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [rmq_pkg::CFG_LEN_W-1:0]         array_length_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  rmq_pkg::in_word_t                     in_data_i,
  output logic                                  res_valid_o,
  input  logic                                  res_ready_i,
  output rmq_pkg::out_word_t                    res_o,
  output logic                                  mem_we_o,
  output logic [$clog2(2*LEAVES)-1:0]           mem_waddr_o,
  output rmq_pkg::value_t                       mem_wdata_o,
  output logic                                  mem_re_o,
  output logic [$clog2(2*LEAVES)-1:0]           mem_raddr_o,
  input  rmq_pkg::value_t                       mem_rdata_i
);
  import rmq_pkg::*;

  localparam int unsigned AW = $clog2(2 * LEAVES);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned CW = (NW > CFG_LEN_W) ? NW : CFG_LEN_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(2 * LEAVES - 1);
  localparam logic [AW-1:0] ROOT     = AW'(1);
  localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QRY_L,
    ST_QRY_R,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   clr_q;
  logic [AW-1:0]   node_q;
  value_t          val_q;
  logic [NW-1:0]   l_q;
  logic [NW-1:0]   r_q;
  value_t          best_q;
  logic            empty_q;
  logic            pend_q;

  logic [CW-1:0]   len_ext;
  logic [CW-1:0]   eff_len;
  logic [CW-1:0]   idx_c;
  logic [CW-1:0]   lo_c;
  logic [CW-1:0]   hi_c;
  logic [CW-1:0]   hi_clip;
  logic            wr_ok;
  logic            q_ok;
  logic [NW-1:0]   l_init;
  logic [NW-1:0]   r_init;
  logic [AW-1:0]   leaf_addr;
  logic            accept;
  value_t          upd_max;
  value_t          best_cur;

  // Decode of the incoming word; the effective length is min(array_length, LEAVES).
  always_comb begin
    len_ext   = CW'(array_length_i);
    eff_len   = (len_ext < LEAVES_C) ? len_ext : LEAVES_C;
    idx_c     = CW'(in_data_i.element_index);
    lo_c      = CW'(in_data_i.range_start);
    hi_c      = CW'(in_data_i.range_end);
    wr_ok     = idx_c < eff_len;
    q_ok      = (lo_c <= hi_c) && (lo_c < eff_len);
    hi_clip   = (hi_c > eff_len - CW'(1)) ? eff_len - CW'(1) : hi_c;
    l_init    = NW'(lo_c + LEAVES_C);
    r_init    = NW'(hi_clip + LEAVES_C + CW'(1));
    leaf_addr = AW'(idx_c + LEAVES_C);
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign upd_max    = smax(val_q, mem_rdata_i);
  assign best_cur   = pend_q ? smax(best_q, mem_rdata_i) : best_q;

  assign res_valid_o       = (state_q == ST_DONE);
  assign res_o.max_value   = best_q;
  assign res_o.empty_res   = empty_q;

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = clr_q;
    mem_wdata_o = INT_MIN;
    mem_re_o    = 1'b0;
    mem_raddr_o = node_q ^ ROOT;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o = 1'b1;
      end
      ST_IDLE: begin
        mem_we_o    = accept && (in_data_i.cmd == CMD_WRITE) && wr_ok;
        mem_waddr_o = leaf_addr;
        mem_wdata_o = in_data_i.element_value;
      end
      ST_UPD_RD: begin
        // The path value is carried in val_q, so only the sibling is read.
        mem_re_o = (node_q != ROOT);
      end
      ST_UPD_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = node_q >> 1;
        mem_wdata_o = upd_max;
      end
      ST_QRY_L: begin
        mem_re_o    = (l_q < r_q) && l_q[0];
        mem_raddr_o = AW'(l_q);
      end
      ST_QRY_R: begin
        mem_re_o    = r_q[0];
        mem_raddr_o = AW'(r_q - NW'(1));
      end
      ST_DONE: begin
        mem_we_o = 1'b0;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      node_q  <= ROOT;
      val_q   <= INT_MIN;
      l_q     <= '0;
      r_q     <= '0;
      best_q  <= INT_MIN;
      empty_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == CLR_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_data_i.cmd == CMD_WRITE) begin
              if (wr_ok) begin
                node_q  <= leaf_addr;
                val_q   <= in_data_i.element_value;
                state_q <= ST_UPD_RD;
              end
            end else if (q_ok) begin
              l_q     <= l_init;
              r_q     <= r_init;
              best_q  <= INT_MIN;
              empty_q <= 1'b0;
              pend_q  <= 1'b0;
              state_q <= ST_QRY_L;
            end else begin
              best_q  <= INT_MIN;
              empty_q <= 1'b1;
              state_q <= ST_DONE;
            end
          end
        end
        ST_UPD_RD: begin
          state_q <= (node_q == ROOT) ? ST_IDLE : ST_UPD_WR;
        end
        ST_UPD_WR: begin
          val_q   <= upd_max;
          node_q  <= node_q >> 1;
          state_q <= ST_UPD_RD;
        end
        ST_QRY_L: begin
          // Folds in the right-hand read of the previous level, then tests the bounds.
          best_q <= best_cur;
          pend_q <= l_q[0];
          state_q <= (l_q < r_q) ? ST_QRY_R : ST_DONE;
        end
        ST_QRY_R: begin
          best_q  <= best_cur;
          pend_q  <= r_q[0];
          l_q     <= (l_q + NW'(l_q[0])) >> 1;
          r_q     <= (r_q - NW'(r_q[0])) >> 1;
          state_q <= ST_QRY_L;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/range_max_query_tree.sv
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid_i / in_stall_o | rmq_pkg::in_word_t
// out     | output    | out_valid_o / out_stall_i | rmq_pkg::out_word_t
// cfg     | input     | cfg_valid_i / cfg_ready_o | array_length, 11 bits
//
// After reset the node memory is swept to the most negative value, one entry per cycle;
// in_stall_o stays high during the sweep.
// An element write stores the leaf, then does one sibling read and one parent write per
// level on the single read port. A query visits each level in two states, one for the left
// and one for the right boundary read. An empty query skips the tree walk.
// A finished result waits in the output register while the next word is taken.
module range_max_query_tree #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  rmq_pkg::in_word_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output rmq_pkg::out_word_t                 out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rmq_pkg::CFG_LEN_W-1:0]      cfg_data_i
);
  import rmq_pkg::*;

  localparam int unsigned DEPTH = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [CFG_LEN_W-1:0] array_length_q;
  logic                 out_valid_q;
  out_word_t            out_data_q;

  logic                 res_valid;
  logic                 res_ready;
  out_word_t            res;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  value_t               mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  value_t               mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      array_length_q <= LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      array_length_q <= cfg_data_i;
    end
  end

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  rmq_ctrl #(
    .LEAVES (LEAVES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .array_length_i (array_length_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  rmq_node_ram #(
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### verif/rmq_checker.sv
`timescale 1ns / 100ps

// Watches all three channels and keeps a shadow copy of the max tree and the length register.
// Every accepted query word queues its expected result. Returned words are checked in order.
module rmq_checker #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  rmq_pkg::in_word_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  rmq_pkg::out_word_t            out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [rmq_pkg::CFG_LEN_W-1:0] cfg_data_i,
  input  logic                          drain_done_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            results_seen_o
);
  import rmq_pkg::*;

  value_t               node_max [1:2*LEAVES-1];
  logic [CFG_LEN_W-1:0] length_reg;
  out_word_t            maxima_due [$];
  int                   failures = 0;
  int                   compared = 0;
  bit                   leftovers_reported = 1'b0;

  function automatic value_t higher(input value_t a, input value_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic int unsigned visible_length();
    return (length_reg < LEAVES) ? length_reg : LEAVES;
  endfunction

  function automatic void set_leaf(input int unsigned idx, input value_t val);
    int unsigned k;
    k = idx + LEAVES;
    node_max[k] = val;
    k = k >> 1;
    while (k >= 1) begin
      node_max[k] = higher(node_max[2*k], node_max[2*k+1]);
      k = k >> 1;
    end
  endfunction

  // Bottom-up walk over the half-open node interval [l, r).
  function automatic value_t interval_max(input int unsigned lo, input int unsigned hi);
    value_t      best;
    int unsigned l;
    int unsigned r;
    best = INT_MIN;
    l = lo + LEAVES;
    r = hi + LEAVES + 1;
    while (l < r) begin
      if ((l & 1) != 0) begin
        best = higher(best, node_max[l]);
        l++;
      end
      if ((r & 1) != 0) begin
        r--;
        best = higher(best, node_max[r]);
      end
      l = l >> 1;
      r = r >> 1;
    end
    return best;
  endfunction

  function automatic out_word_t predict_query(input in_word_t w);
    out_word_t   res;
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    len = visible_length();
    lo = w.range_start;
    hi = w.range_end;
    res.max_value = INT_MIN;
    res.empty_res = 1'b1;
    if (lo <= hi && lo < len) begin
      if (hi > len - 1) hi = len - 1;
      res.max_value = interval_max(lo, hi);
      res.empty_res = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      for (int i = 1; i < 2*LEAVES; i++) node_max[i] = INT_MIN;
      length_reg = LEN_RESET;
      maxima_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (maxima_due.size() == 0) begin
          $error("result word with no query outstanding: max_value %0d, empty_res %0b",
                 out_data_i.max_value, out_data_i.empty_res);
          failures++;
        end else begin
          want = maxima_due.pop_front();
          compared++;
          if (out_data_i.max_value !== want.max_value) begin
            $error("max_value: expected %0d, actual %0d", want.max_value, out_data_i.max_value);
            failures++;
          end
          if (out_data_i.empty_res !== want.empty_res) begin
            $error("empty_res: expected %0b, actual %0b", want.empty_res, out_data_i.empty_res);
            failures++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) length_reg = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.cmd == CMD_QUERY) begin
          maxima_due.push_back(predict_query(in_data_i));
        end else if (in_data_i.element_index < visible_length()) begin
          set_leaf(in_data_i.element_index, in_data_i.element_value);
        end
      end
      if (drain_done_i && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        if (maxima_due.size() != 0) begin
          $error("%0d query results never arrived", maxima_due.size());
          failures++;
        end
      end
    end
    fail_count_o   <= failures;
    pending_o      <= maxima_due.size();
    results_seen_o <= compared;
  end

endmodule

### verif/tb_range_max_query_tree.sv
`timescale 1ns / 100ps

module tb_range_max_query_tree;
  import rmq_pkg::*;

  localparam int unsigned LEAVES         = 1024;
  localparam int          CLK_PERIOD     = 10;
  localparam int          RESET_CYCLES   = 5;
  localparam int          SETTLE_CYCLES  = 64;
  localparam int          LONG_HOLD      = 300;
  localparam int          HOLD_AFTER     = 60;
  localparam int          WATCHDOG_LIMIT = 10000;
  localparam int          PHASES         = 6;
  localparam int          PHASE_WORDS    = 75;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_word_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_word_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_LEN_W-1:0] cfg_data_i;
  logic                 drain_done;

  int fail_count;
  int pending;
  int results_seen;
  int words_sent = 0;
  int idle_cycles = 0;
  int writes_sent = 0;
  int queries_sent = 0;
  int lengths_set = 0;
  bit calm = 1'b0;
  bit long_hold_done = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  range_max_query_tree #(
    .LEAVES(LEAVES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  rmq_checker #(
    .LEAVES(LEAVES)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .drain_done_i  (drain_done),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_seen_o(results_seen)
  );

  // Fields that a command does not use still carry random bits.
  function automatic in_word_t noise_word();
    in_word_t w;
    w.cmd           = 1'($urandom_range(0, 1));
    w.element_index = IDX_W'($urandom_range(0, LEAVES - 1));
    w.element_value = $urandom;
    w.range_start   = IDX_W'($urandom_range(0, LEAVES - 1));
    w.range_end     = IDX_W'($urandom_range(0, LEAVES - 1));
    return w;
  endfunction

  function automatic in_word_t write_word(input int unsigned idx, input value_t val);
    in_word_t w;
    w = noise_word();
    w.cmd           = CMD_WRITE;
    w.element_index = IDX_W'(idx);
    w.element_value = val;
    return w;
  endfunction

  function automatic in_word_t query_word(input int unsigned lo, input int unsigned hi);
    in_word_t w;
    w = noise_word();
    w.cmd         = CMD_QUERY;
    w.range_start = IDX_W'(lo);
    w.range_end   = IDX_W'(hi);
    return w;
  endfunction

  // Mostly writes and queries inside the active length, with some past the end and some
  // entirely random intervals, which also yields reversed ones.
  function automatic in_word_t random_word(input logic [CFG_LEN_W-1:0] cfg_len);
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    value_t      val;
    len = (cfg_len > LEAVES) ? LEAVES : cfg_len;
    if ($urandom_range(0, 99) < 45) begin
      if (len > 0 && $urandom_range(0, 9) < 8) lo = $urandom_range(0, len - 1);
      else lo = $urandom_range(0, LEAVES - 1);
      case ($urandom_range(0, 7))
        0: val = INT_MIN;
        1: val = 32'sh7fff_ffff;
        2: val = -32'sd1;
        3: val = 32'sd0;
        4: val = $signed($urandom_range(0, 200)) - 100;
        default: val = $urandom;
      endcase
      return write_word(lo, val);
    end
    pick = $urandom_range(0, 9);
    if (len == 0 || pick >= 8) begin
      lo = $urandom_range(0, LEAVES - 1);
      hi = $urandom_range(0, LEAVES - 1);
    end else begin
      lo = $urandom_range(0, len - 1);
      if (pick >= 6) begin
        hi = $urandom_range(lo, LEAVES - 1);
      end else if (pick >= 4) begin
        hi = $urandom_range(lo, len - 1);
      end else begin
        hi = lo + $urandom_range(0, 15);
        if (hi > len - 1) hi = len - 1;
      end
    end
    return query_word(lo, hi);
  endfunction

  task automatic send_word(input in_word_t w);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent <= words_sent + 1;
    if (w.cmd == CMD_QUERY) queries_sent++;
    else writes_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // A write word gives no result, so after the last query result the block may still be
  // walking the tree; the settle time covers one full update.
  task automatic write_length(input logic [CFG_LEN_W-1:0] len);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lengths_set++;
  endtask

  initial begin : stimulus
    logic [CFG_LEN_W-1:0] phase_len [PHASES];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    drain_done  = 1'b0;
    phase_len[0] = CFG_LEN_W'(2047);
    phase_len[1] = CFG_LEN_W'(8);
    phase_len[2] = CFG_LEN_W'($urandom_range(1, LEAVES));
    phase_len[3] = CFG_LEN_W'(LEAVES);
    phase_len[4] = CFG_LEN_W'($urandom_range(1, LEAVES));
    phase_len[5] = CFG_LEN_W'(LEAVES);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full length after reset; the first query sees only unwritten elements.
    send_word(query_word(0, LEAVES - 1));
    send_word(write_word(0, 32'sh7fff_ffff));
    send_word(write_word(LEAVES - 1, INT_MIN));
    send_word(write_word(512, -32'sd1));
    send_word(write_word(5, 32'sd0));
    send_word(write_word(LEAVES - 2, -32'sd2));
    send_word(query_word(0, 0));
    send_word(query_word(LEAVES - 1, LEAVES - 1));
    send_word(query_word(1, LEAVES - 2));
    send_word(query_word(0, LEAVES - 1));
    send_word(query_word(600, 5));
    send_word(query_word(513, LEAVES - 1));
    send_word(query_word(LEAVES - 1, 0));
    send_word(query_word(6, 511));

    // Zero length: nothing is stored and every interval is empty.
    write_length('0);
    send_word(write_word(0, 32'sd100));
    send_word(query_word(0, 0));
    send_word(query_word(0, LEAVES - 1));

    write_length(CFG_LEN_W'(1));
    send_word(write_word(0, 32'sd42));
    send_word(write_word(1, 32'sd99));
    send_word(query_word(0, 0));
    send_word(query_word(0, LEAVES - 1));
    send_word(query_word(1, 1));

    // Shrunk length hides the upper elements; the next phase widens it again.
    write_length(CFG_LEN_W'(600));
    send_word(query_word(0, LEAVES - 1));
    send_word(query_word(600, LEAVES - 1));
    send_word(write_word(700, 32'sd5));

    for (int p = 0; p < PHASES; p++) begin
      write_length(phase_len[p]);
      if (p == PHASES - 1) calm <= 1'b1;
      repeat (PHASE_WORDS) send_word(random_word(phase_len[p]));
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    $display("Drove %0d element writes and %0d range queries over %0d length settings,",
             writes_sent, queries_sent, lengths_set + 1);
    $display("including zero, one, shrunk and oversized lengths; %0d results compared.",
             results_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Random stall bursts on the result side, plus one long hold that backs the block up
  // while the sender keeps offering words.
  initial begin : result_backpressure
    out_stall_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && words_sent >= HOLD_AFTER) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // The reset sweep of the node memory is the longest quiet stretch of a correct run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
